// File: rtl/base64_stream_decoder_top_macros.svh
// Assertion macros shared by the checker of the base64 stream decoder.
// Each macro samples on the rising edge of clk and is disabled while reset is active.
`ifndef BASE64_STREAM_DECODER_TOP_MACROS_SVH
`define BASE64_STREAM_DECODER_TOP_MACROS_SVH

// Plain property, checked at every rising clock edge.
`define B64SD_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("base64 stream decoder assertion failed");

// Implication into the following cycle.
`define B64SD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("base64 stream decoder assertion failed");

`endif

// File: rtl/b64sd_pkg.sv
package b64sd_pkg;

	localparam int unsigned CharWidth   = 8;
	localparam int unsigned SextetWidth = 6;
	localparam int unsigned ByteWidth   = 8;
	localparam int unsigned GroupWidth  = 24;
	localparam int unsigned QueueDepth  = 4;

	localparam logic [CharWidth-1:0] PadChar = 8'h3D;

	// Index of a byte inside a decoded group.
	typedef enum logic [1:0] {
		BYTE_HI  = 2'd0,
		BYTE_MID = 2'd1,
		BYTE_LO  = 2'd2
	} byte_idx_t;

	// One decoded group as handed from the front end to the back end.
	typedef struct packed {
		logic [GroupWidth-1:0] bytes;
		byte_idx_t             last_idx;
		logic                  done;
		logic                  err;
	} job_t;

	// Maps one character to its six-bit value; unknown codes give zero.
	function automatic logic [SextetWidth-1:0] sextet_of(input logic [CharWidth-1:0] c);
		logic [SextetWidth-1:0] s;
		s = '0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			s = SextetWidth'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			s = SextetWidth'(c - 8'h61 + 8'd26);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			s = SextetWidth'(c - 8'h30 + 8'd52);
		end else if (c == 8'h2B || c == 8'h2D || c == 8'h2E) begin
			s = 6'd62;
		end else if (c == 8'h2F || c == 8'h5F || c == 8'h2C) begin
			s = 6'd63;
		end
		return s;
	endfunction

endpackage

// File: rtl/b64sd_fifo.sv
module b64sd_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/b64sd_front.sv
module b64sd_front import b64sd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [CharWidth-1:0] char_in,
	input  logic                 stream_end,
	input  logic                 queue_full,
	output logic                 push,
	output job_t                 job
);

	logic [17:0]            buf_q;
	logic [1:0]             pos_q;
	logic                   third_was_pad_q;
	logic [SextetWidth-1:0] s;
	logic                   is_pad;
	logic                   accept;

	assign s        = sextet_of(char_in);
	assign is_pad   = (char_in == PadChar);
	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && (stream_end || pos_q == 2'd3);

	always_comb begin
		job.done     = stream_end;
		job.err      = 1'b0;
		job.bytes    = {buf_q, s};
		job.last_idx = BYTE_LO;
		case (pos_q)
			2'd0: begin
				job.bytes    = '0;
				job.err      = 1'b1;
				job.last_idx = BYTE_HI;
			end
			2'd1: begin
				job.bytes    = {buf_q[17:12], s, 12'd0};
				job.last_idx = BYTE_HI;
			end
			2'd2: begin
				job.bytes    = {buf_q[17:6], s, 6'd0};
				job.last_idx = is_pad ? BYTE_HI : BYTE_MID;
			end
			default: begin
				// A padded fourth character at the end drops one or two bytes.
				if (stream_end && is_pad) begin
					job.last_idx = third_was_pad_q ? BYTE_HI : BYTE_MID;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q           <= '0;
			pos_q           <= '0;
			third_was_pad_q <= 1'b0;
		end else if (accept) begin
			if (push) begin
				buf_q           <= '0;
				pos_q           <= '0;
				third_was_pad_q <= 1'b0;
			end else begin
				pos_q <= pos_q + 1'b1;
				case (pos_q)
					2'd0:    buf_q <= {s, 12'd0};
					2'd1:    buf_q <= {buf_q[17:12], s, 6'd0};
					default: begin
						buf_q           <= {buf_q[17:6], s};
						third_was_pad_q <= is_pad;
					end
				endcase
			end
		end
	end

endmodule

// File: rtl/b64sd_back.sv
module b64sd_back import b64sd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 job_valid,
	input  job_t                 job,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [ByteWidth-1:0] byte_out,
	output logic                 run_last,
	output logic                 text_done,
	output logic                 lone_char_error
);

	byte_idx_t            idx_q;
	logic                 load;
	logic                 at_last;
	logic [ByteWidth-1:0] sel_byte;
	logic                 valid_q;
	logic [ByteWidth-1:0] byte_q;
	logic                 last_q;
	logic                 done_q;
	logic                 err_q;

	assign load    = !valid_q || out_ready;
	assign at_last = (idx_q == job.last_idx);
	assign pop     = load && job_valid && at_last;

	always_comb begin
		case (idx_q)
			BYTE_HI:  sel_byte = job.bytes[23:16];
			BYTE_MID: sel_byte = job.bytes[15:8];
			default:  sel_byte = job.bytes[7:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= BYTE_HI;
		end else if (load) begin
			valid_q <= job_valid;
			if (job_valid) begin
				case (idx_q)
					BYTE_HI:  idx_q <= at_last ? BYTE_HI : BYTE_MID;
					BYTE_MID: idx_q <= at_last ? BYTE_HI : BYTE_LO;
					default:  idx_q <= BYTE_HI;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && job_valid) begin
			byte_q <= sel_byte;
			last_q <= at_last;
			done_q <= at_last && job.done;
			err_q  <= job.err;
		end
	end

	assign out_valid       = valid_q;
	assign byte_out        = byte_q;
	assign run_last        = last_q;
	assign text_done       = done_q;
	assign lone_char_error = err_q;

endmodule

// File: rtl/base64_stream_decoder_top.sv
// Channel   | Direction | tdata            | tlast      | tuser
// s_axis    | in        | [7:0] char_in    | stream_end | none
// m_axis    | out       | [7:0] byte_out   | run_last   | [0] text_done, [1] lone_char_error
//
// One character request is taken in every cycle while the group queue has room.
// Result requests leave at one byte per cycle while the receiver is ready, so a full
// group of four characters gives three byte requests; the first byte of a group is shown
// once its last character has passed the queue write and then the output register.
// Reset is asynchronous and clears the group position, queue pointers and output
// valid; stalls on either side are absorbed by the QUEUE_DEPTH-entry group queue.
module base64_stream_decoder_top import b64sd_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] char_in
	input  logic       s_axis_tlast,  // stream_end
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [7:0] byte_out
	output logic       m_axis_tlast,  // run_last
	output logic [1:0] m_axis_tuser   // [0] text_done, [1] lone_char_error
);

	// The front end classifies each character and builds a group request
	// whenever a group completes or the stream ends.
	logic queue_full;
	logic queue_empty;
	logic push;
	logic pop;
	job_t job_in;
	job_t job_out;

	b64sd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.char_in    (s_axis_tdata),
		.stream_end (s_axis_tlast),
		.queue_full (queue_full),
		.push       (push),
		.job        (job_in)
	);

	// Short queue of decoded groups between the two halves.
	b64sd_fifo #(
		.WIDTH ($bits(job_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (job_in),
		.pop    (pop),
		.rdata  (job_out),
		.full   (queue_full),
		.empty  (queue_empty)
	);

	// The back end serialises each group into one to three byte requests.
	b64sd_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.job_valid       (!queue_empty),
		.job             (job_out),
		.pop             (pop),
		.out_valid       (m_axis_tvalid),
		.out_ready       (m_axis_tready),
		.byte_out        (m_axis_tdata),
		.run_last        (m_axis_tlast),
		.text_done       (m_axis_tuser[0]),
		.lone_char_error (m_axis_tuser[1])
	);

endmodule

// File: rtl/b64sd_checker.sv
`include "base64_stream_decoder_top_macros.svh"

module b64sd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic       m_axis_tlast,
	input logic [1:0] m_axis_tuser
);

	logic out_stall;
	logic err_seen;
	logic done_seen;

	assign out_stall = m_axis_tvalid && !m_axis_tready;
	assign err_seen  = m_axis_tvalid && m_axis_tuser[1];
	assign done_seen = m_axis_tvalid && m_axis_tuser[0];

	`B64SD_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid)
	`B64SD_ASSERT_NEXT(a_out_data_stable, out_stall, $stable(m_axis_tdata))
	`B64SD_ASSERT(a_err_shape, !err_seen || (m_axis_tdata == 8'd0 && m_axis_tlast && m_axis_tuser[0]))
	`B64SD_ASSERT(a_done_is_last, !done_seen || m_axis_tlast)

endmodule

bind base64_stream_decoder_top b64sd_checker u_b64sd_checker (.*);

// File: tb/testbench.sv
module testbench import b64sd_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	// Generous ceiling on the run length, in clock cycles.
	localparam int unsigned CycleLimit = 200000;
	// Least number of random characters to send after the directed table.
	localparam int unsigned RandomChars = 75;
	// Cycles to watch the output once nothing more is expected.
	localparam int unsigned DrainCycles = 20;

	// One decoded result request as seen on the master side.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       done;
		logic       err;
	} dec_result_t;

	// One row of the directed table. Where typed is set, the row's single
	// result is written out by hand instead of being taken from the predictor.
	typedef struct packed {
		logic [7:0]  ch;
		logic        fin;
		logic        typed;
		dec_result_t want;
	} stim_row_t;

	logic       clk;
	logic       arst_n;
	logic       s_axis_tvalid;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata;
	logic       s_axis_tlast;
	logic       m_axis_tvalid;
	logic       m_axis_tready;
	logic [7:0] m_axis_tdata;
	logic       m_axis_tlast;
	logic [1:0] m_axis_tuser;

	// Decoder state held by the predictor: the sextets of the open group with
	// the first one in the top bits, how many characters of the group are held,
	// and whether the third one was the pad character.
	logic [17:0] grp_sextets;
	logic [1:0]  grp_pos;
	logic        grp_third_pad;

	// Bytes the decoder still owes us, oldest first.
	dec_result_t pending_bytes[$];

	int unsigned cycles;
	int unsigned mismatches;
	int unsigned chars_sent;
	// When set, both sides run flat out with no idle cycles at all.
	bit          steady;

	base64_stream_decoder_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever begin
			#5 clk = ~clk;
		end
	end

	// Six-bit value of one character. Both the standard and the URL-safe
	// alphabets are accepted, ',' and '.' are aliases, and anything else,
	// the pad character included, counts as zero.
	function automatic logic [5:0] sextet_value(input logic [7:0] c);
		logic [7:0] v;
		v = 8'd0;
		if (c >= "A" && c <= "Z") begin
			v = c - "A";
		end else if (c >= "a" && c <= "z") begin
			v = c - "a" + 8'd26;
		end else if (c >= "0" && c <= "9") begin
			v = c - "0" + 8'd52;
		end else if (c == "+" || c == "-" || c == ".") begin
			v = 8'd62;
		end else if (c == "/" || c == "_" || c == ",") begin
			v = 8'd63;
		end
		return v[5:0];
	endfunction

	function automatic dec_result_t mk_result(input logic [7:0] d, input logic l,
	                                          input logic dn, input logic e);
		dec_result_t r;
		r.data = d;
		r.last = l;
		r.done = dn;
		r.err  = e;
		return r;
	endfunction

	// Adds one byte to the end of the list of bytes owed.
	function automatic void owe_result(input dec_result_t r);
		pending_bytes.insert(pending_bytes.size(), r);
	endfunction

	// Advances the predictor by one accepted character and queues every byte
	// that the character releases.
	function automatic void decode_char(input logic [7:0] c, input logic fin);
		logic [5:0]  s;
		logic [23:0] n;
		s = sextet_value(c);
		if (!fin) begin
			if (grp_pos == 2'd3) begin
				// The fourth character closes the group: three bytes, and the group starts over.
				n = {grp_sextets, s};
				owe_result(mk_result(n[23:16], 1'b0, 1'b0, 1'b0));
				owe_result(mk_result(n[15:8], 1'b0, 1'b0, 1'b0));
				owe_result(mk_result(n[7:0], 1'b1, 1'b0, 1'b0));
				grp_sextets   = '0;
				grp_pos       = 2'd0;
				grp_third_pad = 1'b0;
			end else begin
				case (grp_pos)
					2'd0: begin
						grp_sextets = {s, 12'd0};
					end
					2'd1: begin
						grp_sextets[11:6] = s;
					end
					default: begin
						grp_sextets[5:0] = s;
						grp_third_pad    = (c == PadChar);
					end
				endcase
				grp_pos = grp_pos + 2'd1;
			end
			return;
		end

		// Final character of the text: flush whatever the group holds.
		case (grp_pos)
			2'd0: begin
				// A single leftover character cannot make a byte.
				owe_result(mk_result(8'h00, 1'b1, 1'b1, 1'b1));
			end
			2'd1: begin
				n = {grp_sextets[17:12], s, 12'd0};
				owe_result(mk_result(n[23:16], 1'b1, 1'b1, 1'b0));
			end
			2'd2: begin
				n = {grp_sextets[17:6], s, 6'd0};
				if (c == PadChar) begin
					owe_result(mk_result(n[23:16], 1'b1, 1'b1, 1'b0));
				end else begin
					owe_result(mk_result(n[23:16], 1'b0, 1'b0, 1'b0));
					owe_result(mk_result(n[15:8], 1'b1, 1'b1, 1'b0));
				end
			end
			default: begin
				n = {grp_sextets, s};
				if (c != PadChar) begin
					owe_result(mk_result(n[23:16], 1'b0, 1'b0, 1'b0));
					owe_result(mk_result(n[15:8], 1'b0, 1'b0, 1'b0));
					owe_result(mk_result(n[7:0], 1'b1, 1'b1, 1'b0));
				end else if (grp_third_pad) begin
					owe_result(mk_result(n[23:16], 1'b1, 1'b1, 1'b0));
				end else begin
					owe_result(mk_result(n[23:16], 1'b0, 1'b0, 1'b0));
					owe_result(mk_result(n[15:8], 1'b1, 1'b1, 1'b0));
				end
			end
		endcase
		grp_sextets   = '0;
		grp_pos       = 2'd0;
		grp_third_pad = 1'b0;
	endfunction

	// Offers one character request and waits for it to be taken. The task is
	// entered and left at a falling edge, so tvalid is only ever assigned once
	// per time step: lowered for an idle stretch, or held high into the next
	// request when no idle cycles were drawn.
	task automatic send_char(input logic [7:0] c, input logic fin, input logic typed,
	                         input dec_result_t want);
		int unsigned gap;
		int          depth_before;
		gap = steady ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= c;
		s_axis_tlast  <= fin;
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		// Taken at this edge: the predictor always runs so that its state
		// stays in step, but a typed row replaces its bytes by the one given.
		depth_before = pending_bytes.size();
		decode_char(c, fin);
		if (typed) begin
			while (pending_bytes.size() > depth_before) begin
				void'(pending_bytes.pop_back());
			end
			owe_result(want);
		end
		chars_sent++;
		@(negedge clk);
	endtask

	// Holds the sender back until every byte owed has been delivered.
	task automatic hold_until_drained();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (pending_bytes.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// One encoded text with random content: mostly alphabet characters, some
	// pad characters anywhere, a little noise from the whole byte range, an
	// occasional early end, and now and then a padded tail.
	task automatic send_random_stream(input string alphabet);
		int unsigned len;
		int unsigned pick;
		int unsigned tail_pads;
		int unsigned k;
		logic [7:0]  c;
		logic        fin;
		len       = $urandom_range(1, 14);
		tail_pads = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
		for (k = 0; k < len; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 80) begin
				c = alphabet[$urandom_range(0, alphabet.len() - 1)];
			end else if (pick < 88) begin
				c = PadChar;
			end else begin
				c = 8'($urandom_range(0, 255));
			end
			if (k + tail_pads >= len) begin
				c = PadChar;
			end
			fin = (k == len - 1) || ($urandom_range(0, 39) == 0);
			send_char(c, fin, 1'b0, '0);
		end
	endtask

	// Receiver: for every result request it draws a number of cycles to stall
	// before showing tready, then waits for the request to be taken.
	initial begin
		int unsigned stall;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 13);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) begin
				@(posedge clk);
			end
			@(negedge clk);
		end
	end

	// Every result request taken is checked against the oldest byte owed.
	always @(posedge clk) begin
		dec_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_bytes.size() == 0) begin
				$error("unexpected result: byte_out %0h run_last %0b text_done %0b lone_char_error %0b",
				       m_axis_tdata, m_axis_tlast, m_axis_tuser[0], m_axis_tuser[1]);
				mismatches++;
			end else begin
				want = pending_bytes.pop_front();
				if (m_axis_tdata !== want.data) begin
					$error("byte_out: expected %0h, got %0h", want.data, m_axis_tdata);
					mismatches++;
				end
				if (m_axis_tlast !== want.last) begin
					$error("run_last: expected %0b, got %0b", want.last, m_axis_tlast);
					mismatches++;
				end
				if (m_axis_tuser[0] !== want.done) begin
					$error("text_done: expected %0b, got %0b", want.done, m_axis_tuser[0]);
					mismatches++;
				end
				if (m_axis_tuser[1] !== want.err) begin
					$error("lone_char_error: expected %0b, got %0b", want.err, m_axis_tuser[1]);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		stim_row_t directed_rows [25];
		string     alphabet;
		int        i;

		alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/-_.,";

		// Directed table. Only the rows whose single result is obvious carry
		// it by hand; all others are left to the predictor.
		directed_rows = '{
			// A lone top-of-range character straight after reset: the error result.
			'{8'hFF, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b1}},
			// Two sextets of all ones at the end give one byte of all ones.
			'{"/",   1'b0, 1'b0, '0},
			'{"/",   1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1, 1'b0}},
			// A full group made only of the URL-safe and alias characters.
			'{"-",   1'b0, 1'b0, '0},
			'{"_",   1'b0, 1'b0, '0},
			'{".",   1'b0, 1'b0, '0},
			'{",",   1'b0, 1'b0, '0},
			// Closing group that is not padded at the end, with a pad character
			// sitting in the third place and counting as zero.
			'{"z",   1'b0, 1'b0, '0},
			'{"9",   1'b0, 1'b0, '0},
			'{PadChar, 1'b0, 1'b0, '0},
			'{"/",   1'b1, 1'b0, '0},
			// Group padded twice: a single byte.
			'{"Q",   1'b0, 1'b0, '0},
			'{"Q",   1'b0, 1'b0, '0},
			'{PadChar, 1'b0, 1'b0, '0},
			'{PadChar, 1'b1, 1'b0, '0},
			// Group padded once: two bytes.
			'{"Q",   1'b0, 1'b0, '0},
			'{"U",   1'b0, 1'b0, '0},
			'{"E",   1'b0, 1'b0, '0},
			'{PadChar, 1'b1, 1'b0, '0},
			// Group cut short after three characters, one of them the zero code.
			'{"Q",   1'b0, 1'b0, '0},
			'{8'h00, 1'b0, 1'b0, '0},
			'{"E",   1'b1, 1'b0, '0},
			// Group cut short with the pad character as its third and last one.
			'{"Q",   1'b0, 1'b0, '0},
			'{"Q",   1'b0, 1'b0, '0},
			'{PadChar, 1'b1, 1'b0, '0}
		};

		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = 8'h00;
		s_axis_tlast  = 1'b0;
		grp_sextets   = '0;
		grp_pos       = 2'd0;
		grp_third_pad = 1'b0;
		cycles        = 0;
		mismatches    = 0;
		chars_sent    = 0;
		steady        = 1'b0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (i = 0; i < 25; i++) begin
			send_char(directed_rows[i].ch, directed_rows[i].fin, directed_rows[i].typed,
			          directed_rows[i].want);
		end

		// Let the decoder empty completely before the random texts start.
		hold_until_drained();

		// Random texts. Some run with no idle cycles on either side, and some
		// start only once everything before them has been delivered.
		while (chars_sent < 25 + RandomChars) begin
			steady = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) == 0) begin
				hold_until_drained();
			end
			send_random_stream(alphabet);
		end
		steady = 1'b0;
		s_axis_tvalid <= 1'b0;

		while (pending_bytes.size() != 0) begin
			@(posedge clk);
		end
		// Keep watching for a while in case stray bytes follow.
		repeat (DrainCycles) @(posedge clk);

		if (mismatches == 0 && pending_bytes.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl
rtl/b64sd_pkg.sv
rtl/b64sd_fifo.sv
rtl/b64sd_front.sv
rtl/b64sd_back.sv
rtl/base64_stream_decoder_top.sv
rtl/b64sd_checker.sv
tb/testbench.sv
